FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expects clk and rst in scope; checks are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/swpc_pkg.sv
package swpc_pkg;

  // Fixed field widths
  localparam int EVENT_TIME_W = 32;
  localparam int STATUS_W     = 10;
  localparam int COUNT_W      = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_FILTER = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Divide a status code by ten: reciprocal 205/2048, exact below 1029
  function automatic logic [STATUS_W-1:0] div10(input logic [STATUS_W-1:0] v);
    logic [17:0] p;
    p = {8'd0, v} * 18'd205;
    return STATUS_W'(p[17:11]);
  endfunction

  // Divide a status code by a hundred: reciprocal 41/4096, exact below 1099
  function automatic logic [STATUS_W-1:0] div100(input logic [STATUS_W-1:0] v);
    logic [17:0] p;
    p = {8'd0, v} * 18'd41;
    return STATUS_W'(p[17:12]);
  endfunction

  // Status matches the filter directly or after dropping one or two digits
  function automatic logic status_hit(input logic [STATUS_W-1:0] st,
                                      input logic [STATUS_W-1:0] filt);
    return (st == filt) || (div10(st) == filt) || (div100(st) == filt);
  endfunction

endpackage

FILE: hdl/swpc_event_if.sv
interface swpc_event_if;
  logic                                valid;
  logic                                ready;
  logic [swpc_pkg::EVENT_TIME_W-1:0]   event_time;
  logic [swpc_pkg::STATUS_W-1:0]       event_status;

  modport source (output valid, output event_time, output event_status, input ready);
  modport sink   (input valid, input event_time, input event_status, output ready);
endinterface

FILE: hdl/swpc_result_if.sv
interface swpc_result_if;
  logic                                valid;
  logic                                ready;
  logic                                status_match;
  logic [swpc_pkg::COUNT_W-1:0]        window_count;
  logic [swpc_pkg::COUNT_W-1:0]        peak_count;
  logic [swpc_pkg::EVENT_TIME_W-1:0]   peak_first_time;
  logic [swpc_pkg::EVENT_TIME_W-1:0]   peak_last_time;
  logic                                overflow;

  modport source (output valid, output status_match, output window_count,
                  output peak_count, output peak_first_time, output peak_last_time,
                  output overflow, input ready);
  modport sink   (input valid, input status_match, input window_count,
                  input peak_count, input peak_first_time, input peak_last_time,
                  input overflow, output ready);
endinterface

FILE: hdl/swpc_cfg_if.sv
interface swpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [swpc_pkg::CFG_IDX_W-1:0]      index;
  logic [swpc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sliding_window_peak_event_count.sv
// Each event is taken only in IDLE. With the store empty it goes straight to FINISH; else
// CHECK pops the entries that fall outside the window, and the pop that leaves only the
// newest entry ends the loop itself. The result is loaded into the output register from
// CHECK or FINISH; no new event is taken until then, and a result held back by ready stalls
// it. The pop loop reads one stored timestamp a cycle through the single memory read port.
// Reset (rst, synchronous, active high) clears indices, counts, peak record,
// configuration and output valid at once; the timestamp memory is not cleared.
`include "assert_macros.svh"

module sliding_window_peak_event_count #(
  parameter int STORE_DEPTH = 1024,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  swpc_event_if.sink           events,
  swpc_result_if.source        results,
  swpc_cfg_if.sink             cfg
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W  = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0]  ONE_COUNT  = CNT_W'(1);

  swpc_pkg::state_t state, state_next;

  logic [ADDR_W-1:0]    head, head_next, tail, tail_next;
  logic [CNT_W-1:0]     held, held_next;
  logic [CNT_W-1:0]     best_count, best_count_next;
  logic [TIME_BITS-1:0] best_first, best_first_next, best_last, best_last_next;
  logic [TIME_BITS-1:0] newest, newest_next, oldest, oldest_next;
  logic                 match, match_next, ovf, ovf_next;

  logic [swpc_pkg::CFG_DATA_W-1:0] time_window;
  logic [swpc_pkg::STATUS_W-1:0]   status_filter;

  logic [TIME_BITS-1:0] time_store [STORE_DEPTH];
  logic [TIME_BITS-1:0] rd_data, t_in;
  logic [ADDR_W-1:0]    rd_addr, head_step, tail_step;
  logic                 wr_en, full, span_ok, out_free;
  logic                 fin_go, out_load;
  logic [TIME_BITS-1:0] fin_oldest;
  logic [CNT_W-1:0]     fin_held;

  assign t_in      = TIME_BITS'(events.event_time);
  assign head_step = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_step = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign full      = (held == FULL_COUNT);
  assign out_free  = !results.valid || results.ready;

  // Oldest entry still inside the window: non-negative span not above the limit
  assign span_ok = (newest >= rd_data) &&
                   (CMP_W'(newest - rd_data) <= CMP_W'(time_window));

  assign events.ready = (state == swpc_pkg::ST_IDLE);
  assign cfg.ready    = 1'b1;

  // Timestamp store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_store[tail] <= t_in;
    end
    rd_data <= time_store[rd_addr];
  end

  // Next state, FIFO update, pop loop and result hand-off
  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    held_next       = held;
    newest_next     = newest;
    oldest_next     = oldest;
    match_next      = match;
    ovf_next        = ovf;
    best_count_next = best_count;
    best_first_next = best_first;
    best_last_next  = best_last;
    rd_addr         = head_step;
    wr_en           = 1'b0;
    fin_go          = 1'b0;
    fin_oldest      = oldest;
    fin_held        = held;
    out_load        = 1'b0;

    unique case (state)
      swpc_pkg::ST_IDLE: begin
        // Read the oldest entry as it stands after any forced drop
        rd_addr = full ? head_step : head;
        if (events.valid) begin
          wr_en       = 1'b1;
          match_next  = swpc_pkg::status_hit(events.event_status, status_filter);
          ovf_next    = full;
          head_next   = full ? head_step : head;
          tail_next   = tail_step;
          held_next   = full ? held : held + 1'b1;
          newest_next = t_in;
          if (held == '0) begin
            oldest_next = t_in;
            state_next  = swpc_pkg::ST_FINISH;
          end else begin
            state_next = swpc_pkg::ST_CHECK;
          end
        end
      end

      swpc_pkg::ST_CHECK: begin
        if (span_ok) begin
          fin_go     = 1'b1;
          fin_oldest = rd_data;
          fin_held   = held;
        end else begin
          // Drop the oldest entry and fetch the one behind it
          head_next = head_step;
          held_next = held - 1'b1;
          if (held - 1'b1 == ONE_COUNT) begin
            fin_go     = 1'b1;
            fin_oldest = newest;
            fin_held   = ONE_COUNT;
          end
        end
        if (fin_go) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = swpc_pkg::ST_IDLE;
          end else begin
            oldest_next = fin_oldest;
            state_next  = swpc_pkg::ST_FINISH;
          end
        end
      end

      swpc_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = swpc_pkg::ST_IDLE;
        end
      end

      default: state_next = swpc_pkg::ST_IDLE;
    endcase

    // Record a strictly larger window
    if (out_load && (fin_held > best_count)) begin
      best_count_next = fin_held;
      best_first_next = fin_oldest;
      best_last_next  = newest;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // FIFO pointers, peak record and per-event working values
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      held       <= '0;
      best_count <= '0;
      best_first <= '0;
      best_last  <= '0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      held       <= held_next;
      best_count <= best_count_next;
      best_first <= best_first_next;
      best_last  <= best_last_next;
    end
    newest <= newest_next;
    oldest <= oldest_next;
    match  <= match_next;
    ovf    <= ovf_next;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      time_window   <= '0;
      status_filter <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        swpc_pkg::REG_TIME_WINDOW:   time_window   <= cfg.data;
        swpc_pkg::REG_STATUS_FILTER: status_filter <= cfg.data[swpc_pkg::STATUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register: hold the result until its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (out_load) begin
      results.status_match    <= match;
      results.window_count    <= swpc_pkg::COUNT_W'(fin_held);
      results.peak_count      <= swpc_pkg::COUNT_W'(best_count_next);
      results.peak_first_time <= swpc_pkg::EVENT_TIME_W'(best_first_next);
      results.peak_last_time  <= swpc_pkg::EVENT_TIME_W'(best_last_next);
      results.overflow        <= ovf;
    end
  end

  `ASSERT_IMPLIES(a_held_bound, 1'b1, held <= FULL_COUNT)
  `ASSERT_IMPLIES(a_check_needs_two, state == swpc_pkg::ST_CHECK, held > ONE_COUNT)
  `ASSERT_IMPLIES(a_ptr_agree, (held == '0) || (held == FULL_COUNT), head == tail)
  `ASSERT_NEXT(a_accept_busy, events.valid && events.ready, state != swpc_pkg::ST_IDLE)
  `ASSERT_IMPLIES(a_peak_covers, results.valid, results.peak_count >= results.window_count)

endmodule
